// ----- design/mmkv_pkg.sv -----
// Shared types and codes for the multi-map key/value table.
// No dependencies.
package mmkv_pkg;

  typedef enum logic [2:0] {
    OP_LOOKUP  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_UPDATE  = 3'd2,
    OP_UPSERT  = 3'd3,
    OP_DELETE  = 3'd4,
    OP_CREATE  = 3'd5,
    OP_DESTROY = 3'd6,
    OP_REPLACE = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NOTFOUND  = 3'd2,
    ST_NOSPACE   = 3'd3,
    ST_BADHANDLE = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_DONE  = 5'b00100,
    S_CLEAR = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

endpackage

// ----- design/multi_map_key_value_table_core.sv -----
// Multi-map key/value table: one request in, one response out.
// Depends on mmkv_pkg.
//
// channel  dir  fields (tdata low bit up)                       tuser
// s_axis   in   op[2:0] handle[6:3] key[70:7] value[134:71]     -
// m_axis   out  status[2:0] found_value[66:3] entry_count[73:67]
//               map_version[105:74] new_handle[109:106]
//
// Lookup, insert, update, upsert and delete scan their map one slot per cycle
// through a registered slot memory, then respond from S_DONE. Create and
// replace sweep the map instead and respond from S_OUT; destroy, bad handles
// and create with no free map respond the next cycle. Slot used bits are
// cleared by a sweep over all NUM_MAPS*ENTRIES_PER_MAP slots after reset,
// while s_axis_tready is low. The next request is taken once the response has
// been accepted.
module multi_map_key_value_table_core
  import mmkv_pkg::*;
#(
  parameter int NUM_MAPS        = 8,
  parameter int ENTRIES_PER_MAP = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [135:0] s_axis_tdata,  // op, handle, key, value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata   // status, found_value, entry_count,
                                      // map_version, new_handle
);

  localparam int SW    = (ENTRIES_PER_MAP > 1) ? $clog2(ENTRIES_PER_MAP) : 1;
  localparam int MW    = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
  localparam int TOTAL = NUM_MAPS * ENTRIES_PER_MAP;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

  // slot memory: used bit, key, value
  logic [128:0] mem [TOTAL];
  logic [128:0] rd_q;
  logic         we;
  logic [AW-1:0] wa, ra;
  logic [128:0] wd;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  logic [NUM_MAPS-1:0] live_q;
  logic [6:0]  cnt_q [NUM_MAPS];
  logic [31:0] ver_q [NUM_MAPS];

  state_e state_q, state_d;
  op_e    op_q;
  logic [MW-1:0] m_q;
  logic [63:0] key_q, val_q;
  logic [SW:0] idx_q;      // scan index, one past slot read
  logic [AW:0] clr_q;      // reset sweep pointer
  logic        rd_v_q;     // rd_q holds slot idx_q-1
  logic        hit_q, free_q;
  logic [SW-1:0] hit_s_q, free_s_q;
  logic        out_v_q;
  logic [109:0] out_q;

  logic [3:0] h_in;
  assign h_in = s_axis_tdata[6:3];

  function automatic logic [AW-1:0] addr(logic [MW-1:0] m, logic [SW-1:0] s);
    return AW'(m * ENTRIES_PER_MAP + s);
  endfunction

  // lowest free map
  logic          any_free;
  logic [MW-1:0] free_m;
  always_comb begin
    any_free = 1'b0;
    free_m   = '0;
    for (int i = NUM_MAPS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        any_free = 1'b1;
        free_m   = MW'(i);
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q && (clr_q == (AW+1)'(TOTAL));
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_q};

  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;

  logic [SW-1:0] cur_s;
  assign cur_s = SW'(idx_q - 1'b1);

  always_comb begin
    we = 1'b0;
    wa = addr(m_q, '0);
    wd = '0;
    ra = addr(m_q, idx_q[SW-1:0]);
    if (clr_q != (AW+1)'(TOTAL)) begin
      we = 1'b1;
      wa = clr_q[AW-1:0];
    end else if (state_q == S_CLEAR) begin
      we = 1'b1;
      wa = addr(m_q, idx_q[SW-1:0]);
      if (op_q == OP_REPLACE && idx_q == '0) wd = {1'b1, key_q, val_q};
    end else if (state_q == S_DONE) begin
      case (op_q)
        OP_INSERT: begin
          we = !hit_q && free_q;
          wa = addr(m_q, free_s_q);
          wd = {1'b1, key_q, val_q};
        end
        OP_UPDATE, OP_UPSERT: begin
          we = hit_q || free_q;
          wa = addr(m_q, hit_q ? hit_s_q : free_s_q);
          wd = {1'b1, key_q, val_q};
        end
        OP_DELETE: begin
          we = hit_q && op_q == OP_DELETE;
          wa = addr(m_q, hit_s_q);
          wd = {1'b0, key_q, val_q};
        end
        default: we = 1'b0;
      endcase
      if (op_q == OP_UPDATE && !hit_q) we = 1'b0;
    end
  end

  logic [2:0]  st;
  logic [63:0] fv;
  logic [6:0]  nc;
  logic [31:0] nv;
  logic        chg;
  always_comb begin
    st  = ST_OK;
    fv  = '0;
    nc  = cnt_q[m_q];
    chg = 1'b0;
    case (op_q)
      OP_LOOKUP: if (hit_q) fv = rd_q[63:0]; else st = ST_NOTFOUND;
      OP_INSERT: begin
        if (hit_q) st = ST_EXISTS;
        else if (!free_q) st = ST_NOSPACE;
        else begin nc = nc + 7'd1; chg = 1'b1; end
      end
      OP_UPDATE: if (hit_q) chg = 1'b1; else st = ST_NOTFOUND;
      OP_UPSERT: begin
        if (hit_q) chg = 1'b1;
        else if (!free_q) st = ST_NOSPACE;
        else begin nc = nc + 7'd1; chg = 1'b1; end
      end
      OP_DELETE: if (hit_q) begin nc = nc - 7'd1; chg = 1'b1; end
                 else st = ST_NOTFOUND;
      default: begin nc = 7'd1; chg = 1'b1; end
    endcase
    nv = ver_q[m_q] + {31'd0, chg};
  end

  logic [63:0] lk_val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      live_q  <= '0;
      for (int i = 0; i < NUM_MAPS; i++) begin
        cnt_q[i] <= '0;
        ver_q[i] <= '0;
      end
      clr_q   <= '0;
      out_v_q <= 1'b0;
      rd_v_q  <= 1'b0;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      free_q  <= 1'b0;
    end else begin
      if (clr_q != (AW+1)'(TOTAL)) clr_q <= clr_q + 1'b1;
      if (out_v_q && m_axis_tready) out_v_q <= 1'b0;
      rd_v_q <= (state_q == S_SCAN) && (idx_q != (SW+1)'(ENTRIES_PER_MAP));
      case (state_q)
        S_IDLE: if (acc) begin
          op_q  <= op_e'(s_axis_tdata[2:0]);
          key_q <= s_axis_tdata[70:7];
          val_q <= s_axis_tdata[134:71];
          m_q   <= (op_e'(s_axis_tdata[2:0]) == OP_CREATE) ? free_m : MW'(h_in - 4'd1);
          idx_q <= '0;
          hit_q <= 1'b0;
          free_q <= 1'b0;
          if (op_e'(s_axis_tdata[2:0]) == OP_CREATE) begin
            if (any_free) begin
              live_q[free_m] <= 1'b1;
              cnt_q[free_m]  <= '0;
              ver_q[free_m]  <= '0;
              state_q <= S_CLEAR;
            end else begin
              out_q   <= {4'd0, 32'd0, 7'd0, 64'd0, ST_NOSPACE};
              out_v_q <= 1'b1;
            end
          end else if (h_in == 4'd0 || h_in > 4'(NUM_MAPS)) begin
            out_q   <= {4'd0, 32'd0, 7'd0, 64'd0, ST_BADHANDLE};
            out_v_q <= 1'b1;
          end else if (op_e'(s_axis_tdata[2:0]) == OP_DESTROY) begin
            live_q[MW'(h_in - 4'd1)] <= 1'b0;
            cnt_q[MW'(h_in - 4'd1)]  <= '0;
            out_q   <= {4'd0, ver_q[MW'(h_in - 4'd1)], 7'd0, 64'd0, ST_OK};
            out_v_q <= 1'b1;
          end else if (!live_q[MW'(h_in - 4'd1)]) begin
            out_q   <= {4'd0, 32'd0, 7'd0, 64'd0, ST_BADHANDLE};
            out_v_q <= 1'b1;
          end else if (op_e'(s_axis_tdata[2:0]) == OP_REPLACE) begin
            state_q <= S_CLEAR;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue read of idx_q, inspect slot idx_q-1
          if (idx_q != (SW+1)'(ENTRIES_PER_MAP)) begin
            idx_q  <= idx_q + 1'b1;
          end
          if (rd_v_q) begin
            if (rd_q[128] && rd_q[127:64] == key_q && !hit_q) begin
              hit_q <= 1'b1;
              hit_s_q <= cur_s;
              lk_val_q <= rd_q[63:0];
            end
            if (!rd_q[128] && !free_q) begin
              free_q <= 1'b1;
              free_s_q <= cur_s;
            end
          end else if (idx_q == (SW+1)'(ENTRIES_PER_MAP)) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          cnt_q[m_q] <= nc;
          ver_q[m_q] <= nv;
          out_q   <= {4'd0, nv, nc, (op_q == OP_LOOKUP && hit_q) ? lk_val_q : fv, st};
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == (SW+1)'(ENTRIES_PER_MAP - 1)) state_q <= S_OUT;
        end
        S_OUT: begin
          if (op_q == OP_CREATE) begin
            out_q <= {4'(m_q) + 4'd1, 32'd0, 7'd0, 64'd0, ST_OK};
          end else begin
            cnt_q[m_q] <= 7'd1;
            ver_q[m_q] <= ver_q[m_q] + 32'd1;
            out_q <= {4'd0, ver_q[m_q] + 32'd1, 7'd1, 64'd0, ST_OK};
          end
          out_v_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // only one word in flight
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> !out_v_q) else $error("accept while response pending");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (state_q == S_IDLE)) else $error("response while busy");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |=> out_v_q) else $error("done without response");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> nc <= 7'(ENTRIES_PER_MAP)) else $error("count overflow");

endmodule
